// File: hw/rtl/macacl_pkg.sv
// ----------------------------------------------------------------------------
// MAC access list package
// Widths, request codes and status codes shared by the sorted MAC table.
// ----------------------------------------------------------------------------
package macacl_pkg;

   localparam int MAC_W         = 48;
   localparam int REQ_TYPE_W    = 2;
   localparam int ENTRY_COUNT_W = 7;

   localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_DELETE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_MATCH  = 2'd2;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

endpackage

// File: hw/rtl/macacl_chan_if.sv
// ----------------------------------------------------------------------------
// MAC access list channels
// Valid/ready channels for requests into the table and responses out of it.
// ----------------------------------------------------------------------------
interface macacl_req_if;
   logic                                valid;
   logic                                ready;
   logic [macacl_pkg::REQ_TYPE_W-1:0]   req_type;
   logic [macacl_pkg::MAC_W-1:0]        mac_addr;

   modport source (output valid, output req_type, output mac_addr, input ready);
   modport sink   (input valid, input req_type, input mac_addr, output ready);
endinterface

interface macacl_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  hit;
   logic                                  status;
   logic [macacl_pkg::ENTRY_COUNT_W-1:0]  entry_count;

   modport source (output valid, output hit, output status, output entry_count,
                   input ready);
   modport sink   (input valid, input hit, input status, input entry_count,
                   output ready);
endinterface

// File: hw/rtl/macacl_ram.sv
// ----------------------------------------------------------------------------
// MAC table storage
// Simple dual-port memory holding the sorted addresses, with registered read.
// ----------------------------------------------------------------------------
module macacl_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [macacl_pkg::MAC_W-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [macacl_pkg::MAC_W-1:0] rd_data
);
   import macacl_pkg::*;

   logic [MAC_W-1:0] mem_ff [DEPTH];
   logic [MAC_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/mac_acl_sorted_table.sv
// ----------------------------------------------------------------------------
// MAC access list, sorted table
// Keeps MAC addresses in ascending order; inserts, deletes and looks up one
// address per transaction using a binary search and an entry-by-entry shift.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake     Payload
//  req_chan  in         valid/ready   req_type, mac_addr
//  rsp_chan  out        valid/ready   hit, status, entry_count
//
//  A response follows a binary search of at most ceil(log2(count + 1))
//  probes; an insert or delete that changes the table then moves the
//  entries behind the position one at a time, and an insert writes its
//  key. Each probe is a memory read followed by a compare on the result,
//  each move a memory read followed by its write; probes and moves share
//  the one memory read port. Reset empties the table at once. A stalled
//  response holds the sequencer in its final state; req_chan.ready is high
//  only while idle, from the cycle in which the response appears.
// ----------------------------------------------------------------------------
module mac_acl_sorted_table #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic          clock,
   input  logic          reset,
   macacl_req_if.sink    req_chan,
   macacl_rsp_if.source  rsp_chan
);
   import macacl_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_PROBE    = 6'b000010,
      ST_COMPARE  = 6'b000100,
      ST_SHIFT_RD = 6'b001000,
      ST_SHIFT_WR = 6'b010000,
      ST_DONE     = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic [MAC_W-1:0]        key_ff, key_in;
   logic [REQ_TYPE_W-1:0]   kind_ff, kind_in;
   logic [CNT_W-1:0]        lo_ff, lo_in;
   logic [CNT_W-1:0]        hi_ff, hi_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    found_ff, found_in;
   logic                    status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic                    rsp_status_ff, rsp_status_in;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [CNT_W-1:0]        mid;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [MAC_W-1:0]        wr_data;
   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;
   logic [MAC_W-1:0]        rd_data;

   macacl_ram #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      kind_in       = kind_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      k_in          = k_ff;
      cnt_in        = cnt_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = IDX_W'(k_ff);
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = IDX_W'(mid);

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               key_in    = req_chan.mac_addr;
               kind_in   = req_chan.req_type;
               lo_in     = '0;
               hi_in     = cnt_ff;
               found_in  = 1'b0;
               status_in = STATUS_OK;
               state_in  = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               state_in = ST_COMPARE;
            end else begin
               // The search has settled: lo_ff is the first entry not below the key.
               case (kind_ff)
                  REQ_INSERT: begin
                     if (found_ff) begin
                        state_in = ST_DONE;
                     end else if (cnt_ff == FULL_COUNT) begin
                        status_in = STATUS_FULL;
                        state_in  = ST_DONE;
                     end else begin
                        k_in     = cnt_ff;
                        state_in = ST_SHIFT_RD;
                     end
                  end
                  REQ_DELETE: begin
                     if (found_ff) begin
                        k_in     = lo_ff;
                        state_in = ST_SHIFT_RD;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_COMPARE: begin
            // Entries are unique, so a present key is always probed on the way.
            if (rd_data < key_ff) begin
               lo_in = mid + CNT_ONE;
            end else begin
               hi_in = mid;
            end
            if (rd_data == key_ff) begin
               found_in = 1'b1;
            end
            state_in = ST_PROBE;
         end
         ST_SHIFT_RD: begin
            if (kind_ff == REQ_INSERT) begin
               if (k_ff > lo_ff) begin
                  rd_en    = 1'b1;
                  rd_addr  = IDX_W'(k_ff - CNT_ONE);
                  state_in = ST_SHIFT_WR;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = IDX_W'(lo_ff);
                  wr_data  = key_ff;
                  cnt_in   = cnt_ff + CNT_ONE;
                  state_in = ST_DONE;
               end
            end else begin
               if ((k_ff + CNT_ONE) < cnt_ff) begin
                  rd_en    = 1'b1;
                  rd_addr  = IDX_W'(k_ff + CNT_ONE);
                  state_in = ST_SHIFT_WR;
               end else begin
                  cnt_in   = cnt_ff - CNT_ONE;
                  state_in = ST_DONE;
               end
            end
         end
         ST_SHIFT_WR: begin
            wr_en = 1'b1;
            if (kind_ff == REQ_INSERT) begin
               k_in = k_ff - CNT_ONE;
            end else begin
               k_in = k_ff + CNT_ONE;
            end
            state_in = ST_SHIFT_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = found_ff;
               rsp_status_in = status_ff;
               rsp_count_in  = ENTRY_COUNT_W'(cnt_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      kind_ff       <= kind_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      k_ff          <= k_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.hit         = rsp_hit_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

endmodule

// File: tb/mac_acl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC access list response checker
// Watches the request and response channels of the sorted MAC table, keeps
// its own copy of the sorted address list, works out the answer to every
// accepted request and compares each accepted response with the oldest
// outstanding answer, field by field.
// ----------------------------------------------------------------------------
module mac_acl_checker #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   macacl_req_if   req_mon,
   macacl_rsp_if   rsp_mon,
   output int      fail_count,
   output int      pending_count
);
   import macacl_pkg::*;

   typedef struct packed {
      logic                     hit;
      logic                     status;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } acl_answer_type;

   // Shadow of the sorted address list and its fill level.
   logic [MAC_W-1:0] acl_entries [TABLE_DEPTH];
   int unsigned      acl_count;
   acl_answer_type   expected_answers [$];

   // Applies one request to the shadow list and returns the answer it causes.
   function automatic acl_answer_type apply_request(input logic [REQ_TYPE_W-1:0] kind,
                                                    input logic [MAC_W-1:0] addr);
      acl_answer_type ans;
      int unsigned    pos;
      logic           present;
      pos = 0;
      while (pos < acl_count && acl_entries[pos] < addr)
         pos++;
      present = (pos < acl_count) && (acl_entries[pos] == addr);
      ans.status = STATUS_OK;
      case (kind)
         REQ_INSERT: begin
            if (!present) begin
               if (acl_count >= TABLE_DEPTH) begin
                  ans.status = STATUS_FULL;
               end else begin
                  for (int k = acl_count; k > pos; k--)
                     acl_entries[k] = acl_entries[k-1];
                  acl_entries[pos] = addr;
                  acl_count++;
               end
            end
         end
         REQ_DELETE: begin
            if (present) begin
               for (int k = pos; k + 1 < acl_count; k++)
                  acl_entries[k] = acl_entries[k+1];
               acl_count--;
            end
         end
         // A match, and the unused code, leave the list as it is.
         default: ;
      endcase
      ans.hit         = present;
      ans.entry_count = acl_count[ENTRY_COUNT_W-1:0];
      return ans;
   endfunction

   initial begin
      fail_count    = 0;
      pending_count = 0;
      acl_count     = 0;
   end

   always @(posedge clock) begin
      acl_answer_type want;
      if (reset) begin
         acl_count = 0;
         expected_answers.delete();
      end else begin
         // The response is checked first: it can never belong to a request
         // accepted on the same edge.
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (expected_answers.size() == 0) begin
               $error("response with nothing outstanding: hit %0b status %0b count %0d",
                      rsp_mon.hit, rsp_mon.status, rsp_mon.entry_count);
               fail_count++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_mon.hit !== want.hit) begin
                  $error("hit: expected %0b, actual %0b", want.hit, rsp_mon.hit);
                  fail_count++;
               end
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0b, actual %0b", want.status, rsp_mon.status);
                  fail_count++;
               end
               if (rsp_mon.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, actual %0d",
                         want.entry_count, rsp_mon.entry_count);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            expected_answers.push_back(apply_request(req_mon.req_type, req_mon.mac_addr));
      end
      pending_count = expected_answers.size();
   end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC access list testbench
// Drives inserts, deletes and lookups into the sorted MAC table: a directed
// opening on the edge cases, then random traffic over a small address pool
// that repeatedly fills and empties the table, under changing flow control.
// ----------------------------------------------------------------------------
module tb;
   import macacl_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int POOL_SIZE   = 80;
   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam logic [MAC_W-1:0]      MAC_ZERO   = 48'h0;
   localparam logic [MAC_W-1:0]      MAC_MAX    = 48'hFFFF_FFFF_FFFF;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   src_idle_pct;
   int   sink_idle_pct;

   logic [MAC_W-1:0] mac_pool [POOL_SIZE];

   macacl_req_if req_chan ();
   macacl_rsp_if rsp_chan ();

   mac_acl_sorted_table #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   mac_acl_checker #(.TABLE_DEPTH(TABLE_DEPTH)) acl_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #2 clock = ~clock;

   // Response back-pressure, redrawn on every falling edge.
   always @(negedge clock)
      rsp_chan.ready = ($urandom_range(99) >= sink_idle_pct);

   function automatic logic [MAC_W-1:0] random_mac();
      logic [15:0] upper;
      logic [31:0] lower;
      upper = 16'($urandom_range(16'hFFFF));
      lower = $urandom();
      return {upper, lower};
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input logic [REQ_TYPE_W-1:0] kind,
                               input logic [MAC_W-1:0] addr);
      while ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid    = 1'b1;
      req_chan.req_type = kind;
      req_chan.mac_addr = addr;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic wait_for_answers();
      req_chan.valid = 1'b0;
      while (pending_count != 0)
         @(negedge clock);
   endtask

   // Mostly pool addresses so that inserts collide, deletes find their target
   // and the table reaches its full state.
   task automatic random_burst(input int count, input int insert_pct, input int delete_pct);
      logic [REQ_TYPE_W-1:0] kind;
      logic [MAC_W-1:0]      addr;
      int                    pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < insert_pct)
            kind = REQ_INSERT;
         else if (pick < insert_pct + delete_pct)
            kind = REQ_DELETE;
         else if (pick >= 96)
            kind = REQ_UNUSED;
         else
            kind = REQ_MATCH;
         if ($urandom_range(99) < 75)
            addr = mac_pool[$urandom_range(POOL_SIZE - 1)];
         else
            addr = random_mac();
         send_request(kind, addr);
      end
   endtask

   task automatic random_phase(input int src_pct, input int sink_pct);
      src_idle_pct  = src_pct;
      sink_idle_pct = sink_pct;
      for (int b = 0; b < 2; b++) begin
         random_burst(108, 70, 10);
         random_burst(108, 15, 60);
      end
      wait_for_answers();
   endtask

   initial begin
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.req_type = REQ_MATCH;
      req_chan.mac_addr = MAC_ZERO;
      src_idle_pct      = 18;
      sink_idle_pct     = 61;

      // Pool with extremes and runs of neighbouring addresses.
      mac_pool[0] = MAC_ZERO;
      mac_pool[1] = MAC_MAX;
      for (int i = 2; i < POOL_SIZE; i++)
         mac_pool[i] = (i % 4 == 0) ? mac_pool[i-1] + 1'b1 : random_mac();

      repeat (7) @(negedge clock);
      reset = 1'b0;

      // Directed opening: empty table, ordering extremes, duplicates,
      // absent deletes, the unused request code and removal at both ends.
      send_request(REQ_MATCH,  MAC_MAX);
      send_request(REQ_DELETE, MAC_ZERO);
      send_request(REQ_INSERT, MAC_MAX);
      send_request(REQ_INSERT, MAC_ZERO);
      send_request(REQ_INSERT, 48'h8000_0000_0000);
      send_request(REQ_INSERT, 48'h7FFF_FFFF_FFFF);
      send_request(REQ_INSERT, 48'h5555_5555_5555);
      send_request(REQ_INSERT, 48'hAAAA_AAAA_AAAA);
      send_request(REQ_INSERT, MAC_ZERO);
      send_request(REQ_INSERT, MAC_MAX);
      send_request(REQ_MATCH,  MAC_ZERO);
      send_request(REQ_MATCH,  MAC_MAX);
      send_request(REQ_MATCH,  48'h8000_0000_0001);
      send_request(REQ_UNUSED, 48'h5555_5555_5555);
      send_request(REQ_UNUSED, 48'h0000_0000_0001);
      send_request(REQ_DELETE, 48'h8000_0000_0000);
      send_request(REQ_DELETE, 48'h8000_0000_0000);
      send_request(REQ_DELETE, MAC_MAX);
      send_request(REQ_DELETE, MAC_ZERO);
      send_request(REQ_MATCH,  MAC_ZERO);
      send_request(REQ_INSERT, 48'h0000_0000_0001);
      send_request(REQ_INSERT, MAC_ZERO);
      send_request(REQ_MATCH,  48'h0000_0000_0001);
      // Hold the sender back until every answer has come out.
      wait_for_answers();

      random_phase(18, 61);
      random_phase(61, 18);
      random_phase(0, 0);

      // Room for any stray response after the last expected one.
      repeat (200) @(negedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
